>>> sv/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce package
// Shared types and constants for the button debouncer with long-press events.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   localparam int TICK_COUNT_BITS_DEFAULT = 17;

   localparam int DEBOUNCE_BITS   = 16;
   localparam int LONG_PRESS_BITS = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [DEBOUNCE_BITS-1:0]   CLICK_DEBOUNCE_TIME = 16'd50;
   localparam logic [LONG_PRESS_BITS-1:0] LONGCLICK_TIME      = 16'd1000;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_LONG    = 2'd2,
      EV_RELEASE = 2'd3
   } event_code_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE_TICKS   = 3'd0,
      CSR_LONG_PRESS_TICKS = 3'd1,
      CSR_PRESSED_ON_HIGH  = 3'd2,
      CSR_PRESS_ENABLE     = 3'd3,
      CSR_LONG_ENABLE      = 3'd4,
      CSR_RELEASE_ENABLE   = 3'd5,
      CSR_LONG_CONSUMES    = 3'd6
   } csr_index_type;

endpackage

>>> sv/bdlp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce channels
// Valid/ready channels for the sampled pin level and the reported event.
// ----------------------------------------------------------------------------
interface bdlp_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

interface bdlp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;
   logic       event_level;

   modport source (output valid, output event_code, output event_level, input ready);
   modport sink (input valid, input event_code, input event_level, output ready);
endinterface

>>> sv/button_debounce_long_press_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debouncer with long press
// Turns one sampled pin level per tick into press, long-press and release
// events.
// ----------------------------------------------------------------------------
// Each request beat carries the pin level sampled at one tick and produces
// exactly one response beat: no event, press, long press or release, with the
// pressed level (or its inverse for release). Events fire only once the level
// has been stable for more than debounce_ticks, and a long press fires once
// the button has stayed pressed for more than long_press_ticks after the
// press. One beat is accepted per cycle whenever the output register is empty
// or being drained; the state update is a single registered pass and the result
// sits in an output register, valid the cycle after acceptance. The user
// writes csr_ port configuration while idle; the block does not enforce it.
module button_debounce_long_press_core #(
   parameter int TICK_COUNT_BITS = bdlp_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bdlp_req_if.sink                             req_chan,
   bdlp_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [bdlp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bdlp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CMP_BITS = (TICK_COUNT_BITS > bdlp_pkg::DEBOUNCE_BITS) ?
                             TICK_COUNT_BITS : bdlp_pkg::DEBOUNCE_BITS;

   logic [bdlp_pkg::DEBOUNCE_BITS-1:0]   debounce_ticks_ff;
   logic [bdlp_pkg::LONG_PRESS_BITS-1:0] long_press_ticks_ff;
   logic pressed_on_high_ff;
   logic press_enable_ff;
   logic long_enable_ff;
   logic release_enable_ff;
   logic long_consumes_ff;

   logic last_pressed_ff, last_pressed_in;
   logic timer_running_ff, timer_running_in;
   logic press_fired_ff, press_fired_in;
   logic long_fired_ff, long_fired_in;
   logic release_fired_ff, release_fired_in;
   logic [TICK_COUNT_BITS-1:0] elapsed_ff, elapsed_in;

   logic                 rsp_valid_ff;
   bdlp_pkg::event_code_type event_code_ff, event_code_in;
   logic                 event_level_ff, event_level_in;

   logic                       accept;
   logic                       pressed;
   logic                       changed;
   logic [TICK_COUNT_BITS-1:0] elapsed_inc;
   logic [CMP_BITS-1:0]        elapsed_cmp;
   logic                       debounced;
   logic                       long_due;

   assign req_chan.ready       = !rsp_valid_ff || rsp_chan.ready;
   assign accept               = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_code  = event_code_ff;
   assign rsp_chan.event_level = event_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= bdlp_pkg::CLICK_DEBOUNCE_TIME;
         long_press_ticks_ff <= bdlp_pkg::LONGCLICK_TIME;
         pressed_on_high_ff  <= 1'b0;
         press_enable_ff     <= 1'b1;
         long_enable_ff      <= 1'b1;
         release_enable_ff   <= 1'b1;
         long_consumes_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            bdlp_pkg::CSR_DEBOUNCE_TICKS:   debounce_ticks_ff <= csr_wdata;
            bdlp_pkg::CSR_LONG_PRESS_TICKS: long_press_ticks_ff <= csr_wdata;
            bdlp_pkg::CSR_PRESSED_ON_HIGH:  pressed_on_high_ff <= csr_wdata[0];
            bdlp_pkg::CSR_PRESS_ENABLE:     press_enable_ff <= csr_wdata[0];
            bdlp_pkg::CSR_LONG_ENABLE:      long_enable_ff <= csr_wdata[0];
            bdlp_pkg::CSR_RELEASE_ENABLE:   release_enable_ff <= csr_wdata[0];
            bdlp_pkg::CSR_LONG_CONSUMES:    long_consumes_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign pressed     = (req_chan.pin_level == pressed_on_high_ff);
   assign changed     = (pressed != last_pressed_ff);
   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
   assign elapsed_cmp = CMP_BITS'(elapsed_inc);
   assign debounced   = timer_running_ff && !changed &&
                        (elapsed_cmp > CMP_BITS'(debounce_ticks_ff));
   assign long_due    = long_enable_ff && !long_fired_ff &&
                        (elapsed_cmp > CMP_BITS'(long_press_ticks_ff));

   always_comb begin
      last_pressed_in  = pressed;
      timer_running_in = timer_running_ff;
      press_fired_in   = press_fired_ff;
      long_fired_in    = long_fired_ff;
      release_fired_in = release_fired_ff;
      elapsed_in       = elapsed_inc;
      event_code_in    = bdlp_pkg::EV_NONE;

      if (debounced) begin
         if (pressed) begin
            if (!press_fired_ff) begin
               if (!long_fired_ff && press_enable_ff) begin
                  event_code_in = bdlp_pkg::EV_PRESS;
               end
               if (!long_enable_ff) begin
                  timer_running_in = 1'b0;
               end
               press_fired_in   = 1'b1;
               long_fired_in    = 1'b0;
               release_fired_in = 1'b0;
               elapsed_in       = '0;
            end else if (long_due) begin
               event_code_in = bdlp_pkg::EV_LONG;
               if (long_consumes_ff) begin
                  press_fired_in   = 1'b0;
                  long_fired_in    = 1'b1;
                  release_fired_in = 1'b0;
               end
               timer_running_in = 1'b0;
            end
         end else begin
            if (!press_fired_ff && !long_fired_ff) begin
               timer_running_in = 1'b0;
            end else if (!release_fired_ff && !long_fired_ff && press_fired_ff) begin
               if (release_enable_ff) begin
                  event_code_in = bdlp_pkg::EV_RELEASE;
               end
               timer_running_in = 1'b0;
               press_fired_in   = 1'b0;
               long_fired_in    = 1'b0;
               release_fired_in = 1'b1;
            end
         end
      end

      if (changed) begin
         elapsed_in       = '0;
         timer_running_in = 1'b1;
      end

      case (event_code_in)
         bdlp_pkg::EV_PRESS,
         bdlp_pkg::EV_LONG:    event_level_in = pressed_on_high_ff;
         bdlp_pkg::EV_RELEASE: event_level_in = !pressed_on_high_ff;
         default:              event_level_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pressed_ff  <= 1'b0;
         timer_running_ff <= 1'b0;
         press_fired_ff   <= 1'b0;
         long_fired_ff    <= 1'b0;
         release_fired_ff <= 1'b0;
         elapsed_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            last_pressed_ff  <= last_pressed_in;
            timer_running_ff <= timer_running_in;
            press_fired_ff   <= press_fired_in;
            long_fired_ff    <= long_fired_in;
            release_fired_ff <= release_fired_in;
            elapsed_ff       <= elapsed_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_code_ff  <= event_code_in;
         event_level_ff <= event_level_in;
      end
   end

endmodule

>>> test/button_debounce_long_press_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debouncer with long press: block-level test
// Drives sampled pin levels through the request channel under random idling on
// both sides, predicts every response beat from an independent model of the
// debounce and long-press rules, and compares the two field by field. The run
// covers the reset settings, short directed sequences, randomized settings
// with mostly clean holds and short bounces, and both 16-bit timing extremes.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core_test;

   localparam int TICK_BITS = bdlp_pkg::TICK_COUNT_BITS_DEFAULT;
   localparam logic [bdlp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int IDLE_PERCENT = 11;
   localparam int STALL_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_TICKS = 36;

   typedef struct packed {
      bdlp_pkg::event_code_type code;
      logic                     level;
   } tick_event_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [bdlp_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [bdlp_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   bdlp_req_if req_chan();
   bdlp_rsp_if rsp_chan();

   button_debounce_long_press_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Settings and state of the predictor.
   logic [bdlp_pkg::DEBOUNCE_BITS-1:0]   cfg_debounce = bdlp_pkg::CLICK_DEBOUNCE_TIME;
   logic [bdlp_pkg::LONG_PRESS_BITS-1:0] cfg_long_ticks = bdlp_pkg::LONGCLICK_TIME;
   bit cfg_on_high = 1'b0;
   bit cfg_press_en = 1'b1;
   bit cfg_long_en = 1'b1;
   bit cfg_release_en = 1'b1;
   bit cfg_consumes = 1'b1;

   bit held_last = 1'b0;
   bit timer_on = 1'b0;
   bit press_done = 1'b0;
   bit long_done = 1'b0;
   bit release_done = 1'b0;
   bit [TICK_BITS-1:0] held_ticks = '0;

   logic           pin_levels[$];
   tick_event_type expected_events[$];

   logic level_taken;
   int   quiet_cycles = 0;
   int   ticks_sent = 0;
   int   events_checked = 0;
   int   press_count = 0;
   int   long_count = 0;
   int   release_count = 0;
   int   mismatches = 0;
   int   settings_written = 0;
   logic no_gaps;

   assign no_gaps = (ticks_sent >= 350) && (ticks_sent < 500);

   function automatic bdlp_pkg::event_code_type settle_level(input bit pressed);
      bdlp_pkg::event_code_type ev;
      ev = bdlp_pkg::EV_NONE;
      if (pressed) begin
         if (!press_done) begin
            if (!long_done && cfg_press_en)
               ev = bdlp_pkg::EV_PRESS;
            if (!cfg_long_en)
               timer_on = 1'b0;
            press_done = 1'b1;
            long_done = 1'b0;
            release_done = 1'b0;
            held_ticks = '0;
         end
         if (cfg_long_en && !long_done && held_ticks > cfg_long_ticks) begin
            ev = bdlp_pkg::EV_LONG;
            if (cfg_consumes) begin
               press_done = 1'b0;
               long_done = 1'b1;
               release_done = 1'b0;
            end
            timer_on = 1'b0;
         end
      end else if (!press_done && !long_done) begin
         timer_on = 1'b0;
      end else if (!release_done && !long_done && press_done) begin
         if (cfg_release_en)
            ev = bdlp_pkg::EV_RELEASE;
         timer_on = 1'b0;
         press_done = 1'b0;
         long_done = 1'b0;
         release_done = 1'b1;
      end
      return ev;
   endfunction

   task automatic predict_tick(input logic pin);
      bit             pressed;
      bit             changed;
      tick_event_type ev;
      pressed = (pin == cfg_on_high);
      changed = (pressed != held_last);
      held_last = pressed;
      if (held_ticks != '1)
         held_ticks++;
      ev.code = bdlp_pkg::EV_NONE;
      ev.level = 1'b0;
      if (timer_on && !changed && held_ticks > cfg_debounce)
         ev.code = settle_level(pressed);
      if (changed) begin
         held_ticks = '0;
         timer_on = 1'b1;
      end
      if (ev.code == bdlp_pkg::EV_PRESS || ev.code == bdlp_pkg::EV_LONG)
         ev.level = cfg_on_high;
      else if (ev.code == bdlp_pkg::EV_RELEASE)
         ev.level = !cfg_on_high;
      expected_events.push_back(ev);
   endtask

   task automatic check_event(input logic [1:0] code, input logic level);
      tick_event_type want;
      if (expected_events.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Unexpected event beat: code %0d level %0d", code, level);
      end else begin
         want = expected_events.pop_front();
         events_checked++;
         if (want.code == bdlp_pkg::EV_PRESS)
            press_count++;
         else if (want.code == bdlp_pkg::EV_LONG)
            long_count++;
         else if (want.code == bdlp_pkg::EV_RELEASE)
            release_count++;
         if (code !== want.code || level !== want.level) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Event beat %0d: expected code %0d level %0d, got code %0d level %0d",
                        events_checked, want.code, want.level, code, level);
         end
      end
   endtask

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (reset) begin
         level_taken <= 1'b0;
      end else begin
         level_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            predict_tick(req_chan.pin_level);
            ticks_sent++;
         end
         if (rsp_chan.valid && rsp_chan.ready)
            check_event(rsp_chan.event_code, rsp_chan.event_level);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", quiet_cycles);
         $display("button_debounce_long_press_core_test NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || level_taken) begin
         if (pin_levels.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_chan.valid <= 1'b1;
            req_chan.pin_level <= pin_levels.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock)
      rsp_chan.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);

   task automatic write_reg(input logic [bdlp_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [bdlp_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         bdlp_pkg::CSR_DEBOUNCE_TICKS:   cfg_debounce = data;
         bdlp_pkg::CSR_LONG_PRESS_TICKS: cfg_long_ticks = data;
         bdlp_pkg::CSR_PRESSED_ON_HIGH:  cfg_on_high = data[0];
         bdlp_pkg::CSR_PRESS_ENABLE:     cfg_press_en = data[0];
         bdlp_pkg::CSR_LONG_ENABLE:      cfg_long_en = data[0];
         bdlp_pkg::CSR_RELEASE_ENABLE:   cfg_release_en = data[0];
         bdlp_pkg::CSR_LONG_CONSUMES:    cfg_consumes = data[0];
         default: ;
      endcase
      settings_written++;
   endtask

   // The single-bit registers get random upper data bits, which must be ignored.
   task automatic load_settings(input logic [15:0] debounce, input logic [15:0] long_ticks,
                                input bit on_high, input bit press_en, input bit long_en,
                                input bit release_en, input bit consumes);
      write_reg(bdlp_pkg::CSR_DEBOUNCE_TICKS, debounce);
      write_reg(bdlp_pkg::CSR_LONG_PRESS_TICKS, long_ticks);
      write_reg(bdlp_pkg::CSR_PRESSED_ON_HIGH, {15'($urandom), on_high});
      write_reg(bdlp_pkg::CSR_PRESS_ENABLE, {15'($urandom), press_en});
      write_reg(bdlp_pkg::CSR_LONG_ENABLE, {15'($urandom), long_en});
      write_reg(bdlp_pkg::CSR_RELEASE_ENABLE, {15'($urandom), release_en});
      write_reg(bdlp_pkg::CSR_LONG_CONSUMES, {15'($urandom), consumes});
      write_reg(CSR_SPARE_INDEX, 16'($urandom));
   endtask

   task automatic hold_level(input logic pin, input int unsigned ticks);
      repeat (ticks) pin_levels.push_back(pin);
   endtask

   task automatic wait_idle();
      while (pin_levels.size() != 0 || req_chan.valid || expected_events.size() != 0)
         @(negedge clock);
   endtask

   // Mostly clean holds around the thresholds, with short bursts of bounce.
   task automatic random_phase();
      int unsigned debounce;
      int unsigned long_ticks;
      int unsigned span;
      int unsigned count;
      int unsigned n;
      logic        pin;
      debounce = $urandom_range(0, 4);
      long_ticks = $urandom_range(0, 12);
      load_settings(16'(debounce), 16'(long_ticks), 1'($urandom_range(0, 1)),
                    $urandom_range(99) < 80, $urandom_range(99) < 80,
                    $urandom_range(99) < 80, $urandom_range(99) < 70);
      span = debounce + long_ticks + 6;
      count = 0;
      pin = 1'($urandom_range(0, 1));
      while (count < PHASE_TICKS) begin
         if ($urandom_range(99) < 80) begin
            pin = !pin;
            n = $urandom_range(1, span);
            hold_level(pin, n);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) pin_levels.push_back(1'($urandom_range(0, 1)));
         end
         count += n;
      end
      wait_idle();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pin_level = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: press, release, a short bounce that is filtered out.
      hold_level(1'b1, 40);
      hold_level(1'b0, 80);
      hold_level(1'b1, 60);
      hold_level(1'b0, 30);
      hold_level(1'b1, 60);
      wait_idle();

      load_settings(16'd0, 16'd2, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      hold_level(1'b1, 6);
      hold_level(1'b0, 3);
      hold_level(1'b1, 3);
      hold_level(1'b0, 3);
      hold_level(1'b1, 1);
      hold_level(1'b0, 3);
      wait_idle();

      load_settings(16'd0, 16'd2, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
      hold_level(1'b1, 6);
      hold_level(1'b0, 3);
      wait_idle();

      repeat (RANDOM_PHASES) random_phase();

      // Longest timings; no hold here is long enough for any event to fire.
      load_settings(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
      hold_level(1'b1, 8);
      hold_level(1'b0, 20);
      hold_level(1'b1, 4);
      wait_idle();

      repeat (6) @(posedge clock);
      $display("Sent %0d pin-level ticks across %0d register writes, timings 0 to 65535.",
               ticks_sent, settings_written);
      $display("Checked %0d event beats: %0d press, %0d long press, %0d release.",
               events_checked, press_count, long_count, release_count);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("button_debounce_long_press_core_test OK");
      end else begin
         $display("%0d mismatches, %0d events never seen", mismatches, expected_events.size());
         $display("button_debounce_long_press_core_test NOT OK");
      end
      $finish;
   end

endmodule
